[design/stl_pkg.sv]
package stl_pkg;

  typedef enum logic [3:0] {
    KIND_LPAREN  = 4'd0,
    KIND_RPAREN  = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_FALSE   = 4'd4,
    KIND_TRUE    = 4'd5,
    KIND_LONG    = 4'd6,
    KIND_DOUBLE  = 4'd7,
    KIND_IDENT   = 4'd8,
    KIND_DEFINE  = 4'd9,
    KIND_BEGIN   = 4'd10,
    KIND_EOS     = 4'd11,
    KIND_INVALID = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_NUMBER   = 3'd1,
    MODE_FRACTION = 3'd2,
    MODE_IDENT    = 3'd3,
    MODE_HASH     = 3'd4,
    MODE_COMMENT  = 3'd5,
    MODE_ERROR    = 3'd6
  } mode_t;

  // Keyword match progress, candidates still alive (bit 0 define, bit 1 begin)
  // and saturating token length.
  typedef struct packed {
    logic [2:0] progress;
    logic [1:0] alive;
    logic [2:0] length;
  } kw_count_t;

  localparam kw_count_t KW_FRESH = '{progress: 3'd0, alive: 2'b11, length: 3'd0};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_char;
    logic       is_text;
    logic       last;
  } result_t;

  // Results produced by one character: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } lex_out_t;

endpackage

[design/scheme_token_lexer_unit.sv]
// Path: input register, then lexing, then the result queue that drives the output.
// Throughput: one character per cycle while out_tready is high and each character gives
// at most one result. A character that closes a token and opens another gives two
// results; the extra one waits in a three-entry result queue while input is held off.
// Reset (synchronous, rst_n low): lexer returns to idle with counters cleared, queue empty.
module scheme_token_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] kind, [11:4] text_char, [15:12] zero
  output logic        out_tuser,  // [0] is_text
  output logic        out_tlast   // last result of a request
);
  import stl_pkg::*;

  localparam int QDepth = 3;

  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       eos_r;

  logic       step;
  logic       pop;
  lex_out_t   lex_out;

  result_t    slot_r   [QDepth];
  result_t    slot_nxt [QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] wpos;
  logic [1:0] push;

  // A character is lexed only when the queue can take two results.
  assign step      = in_valid_r && (cnt_r <= 2'd1);
  assign in_tready = !in_valid_r || (cnt_r <= 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r  <= in_tdata;
      eos_r <= in_tuser;
    end
  end

  stl_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ch      (ch_r),
    .eos     (eos_r),
    .lex_out (lex_out)
  );

  assign pop  = out_tvalid && out_tready;
  assign push = step ? lex_out.count : 2'd0;
  assign wpos = 2'(cnt_r - {1'b0, pop});

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
    for (int i = 0; i < QDepth; i++) begin
      if ((push != 2'd0) && (2'(i) == wpos)) slot_nxt[i] = lex_out.first;
      if ((push == 2'd2) && (2'(i) == 2'(wpos + 2'd1))) slot_nxt[i] = lex_out.second;
    end
    cnt_nxt = 2'(cnt_r - {1'b0, pop} + push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {4'd0, slot_r[0].text_char, 4'(slot_r[0].kind)};
  assign out_tuser  = slot_r[0].is_text;
  assign out_tlast  = slot_r[0].last;

endmodule

[design/stl_lexer.sv]
module stl_lexer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      ch,
  input  logic            eos,
  output stl_pkg::lex_out_t lex_out
);
  import stl_pkg::*;

  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_PLUS   = 8'h2B;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_HASH   = 8'h23;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_SEMI   = 8'h3B;
  localparam logic [7:0] CHR_DOT    = 8'h2E;
  localparam logic [7:0] CHR_NL     = 8'h0A;

  mode_t     mode_r, mode_nxt;
  kw_count_t kw_r, kw_nxt;

  result_t   idle_res;
  logic      idle_emit;
  mode_t     idle_mode;
  kw_count_t idle_kw;

  result_t   res0, res1;
  logic [1:0] n;
  logic      cont, term;
  kind_t     term_kind;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A,
      8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h7E, 8'h5F, 8'h5E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic ident_follow(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || is_special(c) ||
           (c == CHR_DOT) || (c == CHR_PLUS) || (c == CHR_MINUS);
  endfunction

  function automatic logic [7:0] define_char(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      3'd0: r = 8'h64;
      3'd1: r = 8'h65;
      3'd2: r = 8'h66;
      3'd3: r = 8'h69;
      3'd4: r = 8'h6E;
      3'd5: r = 8'h65;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] begin_char(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      3'd0: r = 8'h62;
      3'd1: r = 8'h65;
      3'd2: r = 8'h67;
      3'd3: r = 8'h69;
      3'd4: r = 8'h6E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic kw_count_t count_char(input kw_count_t k, input logic [7:0] c);
    kw_count_t r;
    r = k;
    if (!((k.progress < 3'd6) && (c == define_char(k.progress)))) r.alive[0] = 1'b0;
    if (!((k.progress < 3'd5) && (c == begin_char(k.progress)))) r.alive[1] = 1'b0;
    r.progress = (k.progress < 3'd7) ? 3'(k.progress + 3'd1) : 3'd7;
    r.length   = (k.length < 3'd7) ? 3'(k.length + 3'd1) : 3'd7;
    return r;
  endfunction

  function automatic kind_t ident_kind(input kw_count_t k);
    kind_t r;
    if (k.alive[0] && (k.length == 3'd6)) r = KIND_DEFINE;
    else if (k.alive[1] && (k.length == 3'd5)) r = KIND_BEGIN;
    else r = KIND_IDENT;
    return r;
  endfunction

  function automatic result_t kind_res(input kind_t k);
    return '{kind: k, text_char: 8'd0, is_text: 1'b0, last: 1'b0};
  endfunction

  function automatic result_t text_res(input logic [7:0] c);
    return '{kind: KIND_LPAREN, text_char: c, is_text: 1'b1, last: 1'b0};
  endfunction

  // How a character is lexed when no token is open.
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = kind_res(KIND_INVALID);
    idle_mode = MODE_IDLE;
    idle_kw   = kw_r;
    priority if (ch == CHR_LPAREN) begin
      idle_emit = 1'b1;
      idle_res  = kind_res(KIND_LPAREN);
    end else if (ch == CHR_RPAREN) begin
      idle_emit = 1'b1;
      idle_res  = kind_res(KIND_RPAREN);
    end else if (ch == CHR_PLUS) begin
      idle_emit = 1'b1;
      idle_res  = kind_res(KIND_PLUS);
    end else if (ch == CHR_MINUS) begin
      idle_emit = 1'b1;
      idle_res  = kind_res(KIND_MINUS);
    end else if (ch == CHR_HASH) begin
      idle_mode = MODE_HASH;
    end else if (ch == CHR_SPACE) begin
      idle_mode = MODE_IDLE;
    end else if (ch == CHR_SEMI) begin
      idle_mode = MODE_COMMENT;
    end else if (is_digit(ch)) begin
      idle_emit = 1'b1;
      idle_res  = text_res(ch);
      idle_mode = MODE_NUMBER;
      idle_kw   = count_char(KW_FRESH, ch);
    end else if (is_letter(ch) || is_special(ch)) begin
      idle_emit = 1'b1;
      idle_res  = text_res(ch);
      idle_mode = MODE_IDENT;
      idle_kw   = count_char(KW_FRESH, ch);
    end else begin
      idle_emit = 1'b1;
      idle_res  = kind_res(KIND_INVALID);
      idle_mode = MODE_ERROR;
    end
  end

  always_comb begin
    n         = 2'd0;
    res0      = kind_res(KIND_LPAREN);
    res1      = kind_res(KIND_LPAREN);
    mode_nxt  = mode_r;
    kw_nxt    = kw_r;
    cont      = 1'b0;
    term      = 1'b0;
    term_kind = KIND_LONG;
    if (eos) begin
      // A pending token is closed before the end-of-stream token.
      n = 2'd1;
      unique case (mode_r)
        MODE_NUMBER:   res0 = kind_res(KIND_LONG);
        MODE_FRACTION: res0 = kind_res(KIND_DOUBLE);
        MODE_IDENT:    res0 = kind_res(ident_kind(kw_r));
        MODE_HASH:     res0 = kind_res(KIND_INVALID);
        default:       n = 2'd0;
      endcase
      if (n == 2'd1) res1 = kind_res(KIND_EOS);
      else res0 = kind_res(KIND_EOS);
      n        = 2'(n + 2'd1);
      mode_nxt = MODE_IDLE;
      kw_nxt   = KW_FRESH;
    end else begin
      unique case (mode_r)
        MODE_NUMBER: begin
          if (is_digit(ch)) begin
            cont = 1'b1;
          end else if (ch == CHR_DOT) begin
            cont     = 1'b1;
            mode_nxt = MODE_FRACTION;
          end else begin
            term      = 1'b1;
            term_kind = KIND_LONG;
          end
        end
        MODE_FRACTION: begin
          if (is_digit(ch)) begin
            cont = 1'b1;
          end else begin
            term      = 1'b1;
            term_kind = KIND_DOUBLE;
          end
        end
        MODE_IDENT: begin
          if (ident_follow(ch)) begin
            cont = 1'b1;
          end else begin
            term      = 1'b1;
            term_kind = ident_kind(kw_r);
          end
        end
        MODE_HASH: begin
          n = 2'd1;
          if ((ch == 8'h74) || (ch == 8'h54)) begin
            res0     = kind_res(KIND_TRUE);
            mode_nxt = MODE_IDLE;
          end else if ((ch == 8'h66) || (ch == 8'h46)) begin
            res0     = kind_res(KIND_FALSE);
            mode_nxt = MODE_IDLE;
          end else begin
            res0     = kind_res(KIND_INVALID);
            mode_nxt = MODE_ERROR;
          end
        end
        MODE_COMMENT: begin
          if (ch == CHR_NL) mode_nxt = MODE_IDLE;
        end
        MODE_ERROR: begin
          mode_nxt = MODE_ERROR;
        end
        default: begin
          n        = {1'b0, idle_emit};
          res0     = idle_res;
          mode_nxt = idle_mode;
          kw_nxt   = idle_kw;
        end
      endcase
      if (cont) begin
        n      = 2'd1;
        res0   = text_res(ch);
        kw_nxt = count_char(kw_r, ch);
      end
      // The character that closes a token is lexed again as a fresh one.
      if (term) begin
        n        = idle_emit ? 2'd2 : 2'd1;
        res0     = kind_res(term_kind);
        res1     = idle_res;
        mode_nxt = idle_mode;
        kw_nxt   = idle_kw;
      end
    end
    if (n == 2'd1) res0.last = 1'b1;
    if (n == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      kw_r   <= KW_FRESH;
    end else if (step) begin
      mode_r <= mode_nxt;
      kw_r   <= kw_nxt;
    end
  end

  assign lex_out = '{count: n, first: res0, second: res1};

endmodule
